// ----- sv/hashed_word_dictionary_assert.svh -----
// Assertion macros for the dictionary block.
`ifndef HASHED_WORD_DICTIONARY_ASSERT_SVH
`define HASHED_WORD_DICTIONARY_ASSERT_SVH
// Implication checked at every clock edge outside reset.
`define HWD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define HWD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/hwd_pkg.sv -----
package hwd_pkg;
  localparam int Buckets = 65536;
  localparam int Entries = 131072;
  localparam int WordBytes = 10;
  localparam int BucketBits = $clog2(Buckets);
  localparam int EntryBits = $clog2(Entries);
  localparam int CountBits = EntryBits + 1;
  // head word: valid bit over entry index
  localparam int HeadBits = EntryBits + 1;
  // entry word: link valid, link, value high, value low, key high, key low
  localparam int EntryWordBits = 1 + EntryBits + 16 + 64 + 16 + 64;

  localparam logic [1:0] StInserted = 2'd0;
  localparam logic [1:0] StFull = 2'd1;
  localparam logic [1:0] StFound = 2'd2;
  localparam logic [1:0] StMiss = 2'd3;
  localparam logic [63:0] MissWord = 64'h6865;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_HREAD, S_HWAIT, S_DECIDE,
    S_EREAD, S_EWAIT, S_CMP, S_OUT
  } state_t;

  typedef struct packed {
    logic load;        // capture input item
    logic hash_step;   // fold one key byte
    logic clr_step;    // clear next bucket
    logic head_rd;     // read bucket head
    logic entry_rd;    // read entry at walk index
    logic do_insert;   // write entry and head
    logic follow;      // step walk to link
    logic set_full;
    logic set_found;
    logic set_miss;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic hash_done;
    logic is_lookup;
    logic full;
    logic walk_valid;
    logic key_match;
  } sts_t;

  // Clear bytes after the first zero byte and at or beyond WordBytes.
  function automatic logic [79:0] normalize(input logic [79:0] w);
    logic [79:0] r;
    logic live;
    r = '0;
    live = 1'b1;
    for (int i = 0; i < 10; i++) begin
      if (w[8*i +: 8] == 8'd0 || i >= WordBytes) live = 1'b0;
      if (live) r[8*i +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

  function automatic logic [27:0] elf_step(input logic [27:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = {h, 4'd0} + {24'd0, b};
    t = t ^ {24'd0, t[31:28], 4'd0};
    return t[27:0];
  endfunction
endpackage

// ----- sv/hashed_word_dictionary.sv -----
// Channel  | Handshake          | Payload
// input    | in_valid/in_stall  | mode, key_low/high, value_low/high
// output   | out_valid/out_stall| status, result_low/high
// An item takes an accept state, the hash states (one key byte each through
// the ELF fold), the bucket head read, wait and decision, then on a lookup a
// registered entry RAM read, wait, compare and decide for each chain entry
// passed over, a read, wait and compare for the matching entry, then output.
// After reset the bucket head RAM is swept clear, one bucket a cycle, all
// 65536 buckets, while in_stall stays high.
// The result holds on its ports until out_stall drops; no new item is taken
// while a result waits.
module hashed_word_dictionary (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [63:0] key_low,
  input  logic [15:0] key_high,
  input  logic [63:0] value_low,
  input  logic [15:0] value_high,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] result_low,
  output logic [15:0] result_high
);
  import hwd_pkg::*;
  `include "hashed_word_dictionary_assert.svh"

  cmd_t cmd;
  sts_t sts;

  // Clear the heads after reset, then sequence each item: hash, head read, insert, full or chain walk, deliver.
  hwd_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  // Hold the item, the hash, the tables and the result register.
  hwd_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .mode(mode),
    .key_low(key_low), .key_high(key_high), .value_low(value_low),
    .value_high(value_high), .status(status), .result_low(result_low),
    .result_high(result_high)
  );

  `HWD_ASSERT_IMP(a_no_take_while_out, out_valid, in_stall, "input taken while result waits")
  `HWD_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(status),
    "stalled result changed")
  `HWD_ASSERT_IMP(a_one_write, cmd.do_insert, !cmd.clr_step, "insert during clear sweep")
endmodule

// ----- sv/hwd_ram.sv -----
module hwd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// ----- sv/hwd_ctrl.sv -----
module hwd_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  hwd_pkg::sts_t sts,
  output hwd_pkg::cmd_t cmd
);
  import hwd_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash_step = 1'b1;
        if (sts.hash_done) state_next = S_HREAD;
      end
      S_HREAD: begin
        cmd.head_rd = 1'b1;
        state_next = S_HWAIT;
      end
      S_HWAIT: state_next = S_DECIDE;
      S_DECIDE: begin
        if (!sts.is_lookup) begin
          if (sts.full) cmd.set_full = 1'b1;
          else cmd.do_insert = 1'b1;
          state_next = S_OUT;
        end else if (sts.walk_valid) begin
          state_next = S_EREAD;
        end else begin
          cmd.set_miss = 1'b1;
          state_next = S_OUT;
        end
      end
      S_EREAD: begin
        cmd.entry_rd = 1'b1;
        state_next = S_EWAIT;
      end
      S_EWAIT: state_next = S_CMP;
      S_CMP: begin
        if (sts.key_match) begin
          cmd.set_found = 1'b1;
          state_next = S_OUT;
        end else begin
          cmd.follow = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end
endmodule

// ----- sv/hwd_datapath.sv -----
module hwd_datapath (
  input  logic          clk,
  input  logic          rst,
  input  hwd_pkg::cmd_t cmd,
  output hwd_pkg::sts_t sts,
  input  logic          mode,
  input  logic [63:0]   key_low,
  input  logic [15:0]   key_high,
  input  logic [63:0]   value_low,
  input  logic [15:0]   value_high,
  output logic [1:0]    status,
  output logic [63:0]   result_low,
  output logic [15:0]   result_high
);
  import hwd_pkg::*;

  logic                     is_lookup;
  logic [79:0]              key, val;
  logic [27:0]              hash;
  logic [3:0]               byte_idx;
  logic [BucketBits:0]      clr_idx;
  logic [CountBits-1:0]     count;
  logic                     walk_valid;
  logic [EntryBits-1:0]     walk_idx;
  logic [CountBits-1:0]     steps;
  logic [HeadBits-1:0]      head_rdata, head_wdata;
  logic [EntryWordBits-1:0] entry_rdata, entry_wdata;
  logic                     head_we;
  logic [BucketBits-1:0]    head_waddr, bucket;
  logic [7:0]               cur_byte;
  logic                     head_pending;

  assign bucket = hash[BucketBits-1:0];
  assign cur_byte = key[8*byte_idx +: 8];

  // Head RAM: cleared by a sweep after reset, then written by inserts.
  assign head_we = cmd.clr_step || cmd.do_insert;
  assign head_waddr = cmd.clr_step ? clr_idx[BucketBits-1:0] : bucket;
  assign head_wdata = cmd.clr_step ? '0 : {1'b1, count[EntryBits-1:0]};
  assign entry_wdata = {head_rdata, val, key};

  hwd_ram #(.Width(HeadBits), .Depth(Buckets)) u_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(cmd.head_rd), .raddr(bucket), .rdata(head_rdata)
  );

  hwd_ram #(.Width(EntryWordBits), .Depth(Entries)) u_entry (
    .clk(clk), .we(cmd.do_insert), .waddr(count[EntryBits-1:0]),
    .wdata(entry_wdata), .re(cmd.entry_rd), .raddr(walk_idx), .rdata(entry_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      count <= '0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.do_insert) count <= count + 1'b1;
    end
  end

  // Head data is valid the cycle after the read; latch it once.
  always_ff @(posedge clk) begin
    if (rst) head_pending <= 1'b0;
    else head_pending <= cmd.head_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_lookup <= mode;
      key <= normalize({key_high, key_low});
      val <= normalize({value_high, value_low});
      hash <= '0;
      byte_idx <= '0;
    end
    if (cmd.hash_step) begin
      // a zero byte ends the word, so folding stops adding
      if (cur_byte != 8'd0) hash <= elf_step(hash, cur_byte);
      byte_idx <= byte_idx + 1'b1;
    end
    if (cmd.head_rd) steps <= '0;
    if (head_pending) begin
      walk_valid <= head_rdata[HeadBits-1];
      walk_idx <= head_rdata[EntryBits-1:0];
    end
    if (cmd.follow) begin
      walk_valid <= entry_rdata[EntryWordBits-1] && (steps + 1'b1 < CountBits'(Entries));
      walk_idx <= entry_rdata[EntryWordBits-2 -: EntryBits];
      steps <= steps + 1'b1;
    end
    if (cmd.do_insert) begin
      status <= StInserted; result_low <= '0; result_high <= '0;
    end
    if (cmd.set_full) begin
      status <= StFull; result_low <= '0; result_high <= '0;
    end
    if (cmd.set_miss) begin
      status <= StMiss; result_low <= MissWord; result_high <= '0;
    end
    if (cmd.set_found) begin
      status <= StFound;
      result_low <= entry_rdata[80 +: 64];
      result_high <= entry_rdata[144 +: 16];
    end
  end

  assign sts.clr_done = (clr_idx == (BucketBits+1)'(Buckets - 1));
  assign sts.hash_done = (byte_idx == 4'd9);
  assign sts.is_lookup = is_lookup;
  assign sts.full = (count >= CountBits'(Entries));
  assign sts.walk_valid = head_pending ? head_rdata[HeadBits-1] : walk_valid;
  assign sts.key_match = (entry_rdata[79:0] == key);
endmodule
